>>> hw/rtl/vdh_pkg.sv
package vdh_pkg;

    // Store geometry and counter widths
    localparam int MAX_BINS  = 65536;
    localparam int ADDR_W    = $clog2(MAX_BINS);
    localparam int COUNT_W   = 32;
    localparam int FRAME_W   = 32;
    localparam int FRAC_BITS = 12;
    localparam int HALF      = 1 << (FRAC_BITS - 1);

    // Field and datapath widths
    localparam int POS_W      = 24;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PPN_W      = 8;
    localparam int BINS_W     = 9;
    localparam int PROD_W     = DIFF_W + PPN_W + 1;
    localparam int IDX_W      = BINS_W;
    localparam int ZY_W       = 2 * BINS_W;
    localparam int LIN_W      = 3 * BINS_W;
    localparam int TARGET_W   = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [PPN_W-1:0]  PPN_RESET  = PPN_W'(10);
    localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(40);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FRAME = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN = 3'd0,
        REG_Y_ORIGIN = 3'd1,
        REG_Z_ORIGIN = 3'd2,
        REG_PPN      = 3'd3,
        REG_X_BINS   = 3'd4,
        REG_Y_BINS   = 3'd5,
        REG_Z_BINS   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WAIT
    } back_state_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_t               op;
        logic              counted;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic               counted;
        logic [ADDR_W-1:0]  bin_address;
        logic [COUNT_W-1:0] bin_count;
        logic [FRAME_W-1:0] frames_seen;
    } res_t;

    // Back status seen by the front
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

>>> hw/rtl/vdh_front.sv
module vdh_front
    import vdh_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [OP_W-1:0]             op,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic [TARGET_W-1:0]         target_bin,
    input  back_status_t                back_stat,
    output logic                        cmd_valid,
    output cmd_t                        cmd,
    input  logic                        cmd_full
);

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } axis_t;

    // Round half away from zero and range check one axis
    function automatic axis_t axis_map(input logic signed [PROD_W-1:0] prod,
                                       input logic [BINS_W-1:0] size);
        logic signed [PROD_W-1:0]    rnd;
        logic [PROD_W-FRAC_BITS-1:0] r;
        axis_t                       a;
        rnd = prod + PROD_W'(HALF);
        r   = rnd[PROD_W-1:FRAC_BITS];
        if (prod < 0)
        begin
            a.ok  = (rnd > 0) && (size != '0);
            a.idx = '0;
        end
        else
        begin
            a.ok  = r < (PROD_W-FRAC_BITS)'(size);
            a.idx = r[IDX_W-1:0];
        end
        return a;
    endfunction

    logic signed [POS_W-1:0] x_origin_reg, y_origin_reg, z_origin_reg;
    logic [PPN_W-1:0]        ppn_reg;
    logic [BINS_W-1:0]       x_bins_reg, y_bins_reg, z_bins_reg;

    logic                    advance;
    logic                    in_take;

    // Stage 1: products
    logic                     s1_valid_reg;
    op_t                      s1_op_reg;
    logic [TARGET_W-1:0]      s1_target_reg;
    logic signed [PROD_W-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
    logic signed [PPN_W:0]    ppn_s;
    logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

    // Stage 2: grid indexes
    logic                s2_valid_reg;
    op_t                 s2_op_reg;
    logic [TARGET_W-1:0] s2_target_reg;
    logic                s2_ok_reg;
    logic [IDX_W-1:0]    s2_xi_reg, s2_yi_reg, s2_zi_reg;
    axis_t               ax_x, ax_y, ax_z;

    // Stage 3: partial address
    logic                s3_valid_reg;
    op_t                 s3_op_reg;
    logic [TARGET_W-1:0] s3_target_reg;
    logic                s3_ok_reg;
    logic [IDX_W-1:0]    s3_xi_reg;
    logic [ZY_W-1:0]     s3_zy_reg;
    logic [ZY_W-1:0]     zy;

    // Stage 4: classified item
    logic                s4_valid_reg;
    cmd_t                s4_cmd_reg;
    logic [LIN_W-1:0]    lin;
    logic                in_grid;
    cmd_t                cmd_next;

    // Hold every stage while the last one cannot hand off
    assign advance = !s4_valid_reg || !cmd_full;
    assign full    = !advance || back_stat.clearing;
    assign in_take = push && !full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            z_origin_reg <= '0;
            ppn_reg      <= PPN_RESET;
            x_bins_reg   <= BINS_RESET;
            y_bins_reg   <= BINS_RESET;
            z_bins_reg   <= BINS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                REG_Z_ORIGIN: z_origin_reg <= cfg_data;
                REG_PPN:      ppn_reg      <= cfg_data[PPN_W-1:0];
                REG_X_BINS:   x_bins_reg   <= cfg_data[BINS_W-1:0];
                REG_Y_BINS:   y_bins_reg   <= cfg_data[BINS_W-1:0];
                REG_Z_BINS:   z_bins_reg   <= cfg_data[BINS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Offset and scale each coordinate
    always_comb
    begin
        ppn_s  = {1'b0, ppn_reg};
        diff_x = DIFF_W'(pos_x) - DIFF_W'(x_origin_reg);
        diff_y = DIFF_W'(pos_y) - DIFF_W'(y_origin_reg);
        diff_z = DIFF_W'(pos_z) - DIFF_W'(z_origin_reg);
        prod_x = PROD_W'(diff_x) * PROD_W'(ppn_s);
        prod_y = PROD_W'(diff_y) * PROD_W'(ppn_s);
        prod_z = PROD_W'(diff_z) * PROD_W'(ppn_s);
    end

    // Round and range check
    always_comb
    begin
        ax_x = axis_map(s1_px_reg, x_bins_reg);
        ax_y = axis_map(s1_py_reg, y_bins_reg);
        ax_z = axis_map(s1_pz_reg, z_bins_reg);
    end

    // Linear address and final classification
    always_comb
    begin
        zy       = ZY_W'(s2_zi_reg) * ZY_W'(y_bins_reg) + ZY_W'(s2_yi_reg);
        lin      = LIN_W'(s3_zy_reg) * LIN_W'(x_bins_reg) + LIN_W'(s3_xi_reg);
        in_grid  = s3_ok_reg && (32'(lin) < 32'(MAX_BINS));
        cmd_next.op      = s3_op_reg;
        cmd_next.counted = (s3_op_reg == OP_ADD) && in_grid;
        if (s3_op_reg == OP_ADD)
            cmd_next.addr = in_grid ? lin[ADDR_W-1:0] : '0;
        else
            cmd_next.addr = ADDR_W'(s3_target_reg);
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= op_t'(op);
            s1_target_reg <= target_bin;
            s1_px_reg     <= prod_x;
            s1_py_reg     <= prod_y;
            s1_pz_reg     <= prod_z;

            s2_op_reg     <= s1_op_reg;
            s2_target_reg <= s1_target_reg;
            s2_ok_reg     <= ax_x.ok && ax_y.ok && ax_z.ok;
            s2_xi_reg     <= ax_x.idx;
            s2_yi_reg     <= ax_y.idx;
            s2_zi_reg     <= ax_z.idx;

            s3_op_reg     <= s2_op_reg;
            s3_target_reg <= s2_target_reg;
            s3_ok_reg     <= s2_ok_reg;
            s3_xi_reg     <= s2_xi_reg;
            s3_zy_reg     <= zy;

            s4_cmd_reg    <= cmd_next;
        end
    end

    assign cmd_valid = s4_valid_reg;
    assign cmd       = s4_cmd_reg;

endmodule

>>> hw/rtl/vdh_cmd_queue.sv
module vdh_cmd_queue
    import vdh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic                  do_push, do_pop;

    assign full    = cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Store items
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> hw/rtl/vdh_back.sv
module vdh_back
    import vdh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    input  logic         cmd_empty,
    output logic         cmd_pop,
    output back_status_t back_stat,
    output res_t         res_head,
    output logic         res_empty,
    input  logic         res_pop
);

    localparam int RES_DEPTH = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    back_state_t         state_reg, state_next;
    cmd_t                cur_reg, cur_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;

    // Bin store
    logic [COUNT_W-1:0]  bin_mem [MAX_BINS];
    logic [COUNT_W-1:0]  rd_data_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_wa, mem_ra;
    logic [COUNT_W-1:0]  mem_wd;
    logic [COUNT_W-1:0]  inc_count;

    // Result queue
    res_t                res_slot_reg [RES_DEPTH];
    logic                res_wr_reg, res_rd_reg;
    logic [1:0]          res_cnt_reg;
    logic                res_push, res_take, res_room;
    res_t                res_item;

    assign back_stat.clearing = state_reg == BK_CLEAR;
    assign res_room  = res_cnt_reg != 2'(RES_DEPTH);
    assign res_empty = res_cnt_reg == '0;
    assign res_take  = res_pop && !res_empty;
    assign res_head  = res_slot_reg[res_rd_reg];
    assign inc_count = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            frame_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // Sequence clearing pass, then one item at a time
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        clr_next   = clr_reg;
        frame_next = frame_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = cur_reg.addr;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = cmd.addr;
        res_push   = 1'b0;
        res_item   = '{counted: 1'b0, bin_address: '0, bin_count: '0,
                       frames_seen: frame_reg};
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (!cmd_empty && res_room)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    case (cmd.op)
                        OP_ADD:
                        begin
                            if (cmd.counted)
                            begin
                                mem_re     = 1'b1;
                                state_next = BK_WAIT;
                            end
                            else
                                res_push = 1'b1;
                        end
                        OP_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = BK_WAIT;
                        end
                        OP_CLEAR:
                        begin
                            mem_we   = 1'b1;
                            mem_wa   = cmd.addr;
                            res_push = 1'b1;
                            res_item.bin_address = cmd.addr;
                        end
                        OP_FRAME:
                        begin
                            frame_next = (frame_reg == FRAME_MAX) ? frame_reg
                                                                  : frame_reg + 1'b1;
                            res_push   = 1'b1;
                            res_item.frames_seen = frame_next;
                        end
                        default: ;
                    endcase
                end
            end
            BK_WAIT:
            begin
                res_push   = 1'b1;
                state_next = BK_IDLE;
                res_item.bin_address = cur_reg.addr;
                if (cur_reg.op == OP_ADD)
                begin
                    mem_we   = 1'b1;
                    mem_wd   = inc_count;
                    res_item.counted   = 1'b1;
                    res_item.bin_count = inc_count;
                end
                else
                    res_item.bin_count = rd_data_reg;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Bin store ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= bin_mem[mem_ra];
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (res_push)
                res_wr_reg <= !res_wr_reg;
            if (res_take)
                res_rd_reg <= !res_rd_reg;
            if (res_push && !res_take)
                res_cnt_reg <= res_cnt_reg + 1'b1;
            else if (res_take && !res_push)
                res_cnt_reg <= res_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_slot_reg[res_wr_reg] <= res_item;
    end

    // Result queue never holds more than its depth
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= 2'(RES_DEPTH))
        else $error("result queue overflow");

    // No item leaves the command queue during the clearing pass
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CLEAR |-> !cmd_pop)
        else $error("item taken while clearing");

    // A pending memory read always finishes with a result
    a_wait_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_WAIT |-> res_push)
        else $error("read finished without result");

    // Frame count never goes down
    a_frame_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> frame_reg >= $past(frame_reg))
        else $error("frame count decreased");

endmodule

>>> hw/rtl/voxel_density_histogram_core.sv
// Channel   Handshake                  Fields
// input     push / full                op, pos_x, pos_y, pos_z, target_bin
// result    empty / pop                counted, bin_address, bin_count, frames_seen
// config    cfg_we (no wait)           cfg_index, cfg_data
//
// The front runs a four-stage pipeline (scale, round, two address steps) and can
// take an item every cycle while full is low; the back owns the single-port bin
// store. An add inside the grid or a read is taken in idle and ends in wait
// (read, then for an add write back); a clear, a frame end or an add outside the
// grid finish in idle. After reset the back zeroes the store one bin a cycle:
// full stays high for the whole clearing pass. A four-entry command queue and a
// two-entry result queue let either side stall without stopping the other.
module voxel_density_histogram_core
    import vdh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [OP_W-1:0]         op,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [TARGET_W-1:0]     target_bin,
    output logic                    empty,
    input  logic                    pop,
    output logic                    counted,
    output logic [ADDR_W-1:0]       bin_address,
    output logic [COUNT_W-1:0]      bin_count,
    output logic [FRAME_W-1:0]      frames_seen
);

    back_status_t back_stat;
    logic         fr_valid, q_full, q_empty, q_pop;
    cmd_t         fr_cmd, q_head;
    res_t         res_head;

    vdh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .op         (op),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .target_bin (target_bin),
        .back_stat  (back_stat),
        .cmd_valid  (fr_valid),
        .cmd        (fr_cmd),
        .cmd_full   (q_full)
    );

    vdh_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fr_valid),
        .push_cmd (fr_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    vdh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_head),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .back_stat (back_stat),
        .res_head  (res_head),
        .res_empty (empty),
        .res_pop   (pop)
    );

    // Unpack the oldest result
    assign counted     = res_head.counted;
    assign bin_address = res_head.bin_address;
    assign bin_count   = res_head.bin_count;
    assign frames_seen = res_head.frames_seen;

endmodule

>>> dv/voxel_density_histogram_checker.sv
module voxel_density_histogram_checker
    import vdh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    push,
    input  logic                    full,
    input  logic [OP_W-1:0]         op,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [TARGET_W-1:0]     target_bin,
    input  logic                    empty,
    input  logic                    pop,
    input  logic                    counted,
    input  logic [ADDR_W-1:0]       bin_address,
    input  logic [COUNT_W-1:0]      bin_count,
    input  logic [FRAME_W-1:0]      frames_seen,
    output int unsigned             mismatches,
    output int unsigned             pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the registers
    logic signed [POS_W-1:0] x_org;
    logic signed [POS_W-1:0] y_org;
    logic signed [POS_W-1:0] z_org;
    logic [PPN_W-1:0]        density;
    logic [BINS_W-1:0]       x_size;
    logic [BINS_W-1:0]       y_size;
    logic [BINS_W-1:0]       z_size;

    // Shadow copy of the bin store and the frame counter
    logic [COUNT_W-1:0] voxel_counts [MAX_BINS];
    logic [FRAME_W-1:0] frame_total;

    // Results owed by the block, oldest first
    res_t owed_results [$];

    int unsigned fail_total = 0;
    int unsigned owed_now = 0;

    assign mismatches = fail_total;
    assign pending    = owed_now;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    // Scale, round half away from zero, and range-check one axis
    function automatic bit grid_axis(input logic signed [POS_W-1:0] pos,
                                     input logic signed [POS_W-1:0] origin,
                                     input logic [BINS_W-1:0] size,
                                     output logic [BINS_W-1:0] idx);
        longint prod;
        longint rounded;
        prod = (longint'(pos) - longint'(origin)) * longint'({1'b0, density});
        idx = '0;
        if (prod < 0) begin
            rounded = (-prod + HALF) >>> FRAC_BITS;
            return (rounded == 0) && (size != 0);
        end
        rounded = (prod + HALF) >>> FRAC_BITS;
        if (rounded >= longint'({1'b0, size}))
            return 1'b0;
        idx = rounded[BINS_W-1:0];
        return 1'b1;
    endfunction

    // Apply one item to the shadow state and return the result it causes
    function automatic res_t tally_item(input op_t kind,
                                        input logic signed [POS_W-1:0] px,
                                        input logic signed [POS_W-1:0] py,
                                        input logic signed [POS_W-1:0] pz,
                                        input logic [TARGET_W-1:0] tgt);
        res_t r;
        logic [BINS_W-1:0] xi;
        logic [BINS_W-1:0] yi;
        logic [BINS_W-1:0] zi;
        bit in_x;
        bit in_y;
        bit in_z;
        longint lin;
        r = '0;
        case (kind)
            OP_ADD:
            begin
                in_x = grid_axis(px, x_org, x_size, xi);
                in_y = grid_axis(py, y_org, y_size, yi);
                in_z = grid_axis(pz, z_org, z_size, zi);
                if (in_x && in_y && in_z) begin
                    lin = (longint'(zi) * longint'(y_size) + longint'(yi)) * longint'(x_size)
                          + longint'(xi);
                    if (lin < MAX_BINS) begin
                        // Saturate at the top count
                        if (voxel_counts[lin[ADDR_W-1:0]] != '1)
                            voxel_counts[lin[ADDR_W-1:0]]++;
                        r.counted     = 1'b1;
                        r.bin_address = lin[ADDR_W-1:0];
                        r.bin_count   = voxel_counts[lin[ADDR_W-1:0]];
                    end
                end
            end
            OP_READ:
            begin
                r.bin_address = tgt;
                r.bin_count   = voxel_counts[tgt];
            end
            OP_CLEAR:
            begin
                r.bin_address     = tgt;
                voxel_counts[tgt] = '0;
            end
            default:
            begin
                if (frame_total != '1)
                    frame_total++;
            end
        endcase
        r.frames_seen = frame_total;
        return r;
    endfunction

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n) begin
            x_org       = '0;
            y_org       = '0;
            z_org       = '0;
            density     = PPN_RESET;
            x_size      = BINS_RESET;
            y_size      = BINS_RESET;
            z_size      = BINS_RESET;
            frame_total = '0;
            for (int i = 0; i < MAX_BINS; i++)
                voxel_counts[i] = '0;
            owed_results.delete();
            owed_now <= 0;
        end
        else begin
            // Register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_X_ORIGIN: x_org   = cfg_data[POS_W-1:0];
                    REG_Y_ORIGIN: y_org   = cfg_data[POS_W-1:0];
                    REG_Z_ORIGIN: z_org   = cfg_data[POS_W-1:0];
                    REG_PPN:      density = cfg_data[PPN_W-1:0];
                    REG_X_BINS:   x_size  = cfg_data[BINS_W-1:0];
                    REG_Y_BINS:   y_size  = cfg_data[BINS_W-1:0];
                    REG_Z_BINS:   z_size  = cfg_data[BINS_W-1:0];
                    default:      ;
                endcase
            end

            // Compare an accepted result against the oldest owed one
            if (pop && !empty) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with no item waiting", bin_address, 0);
                end
                else begin
                    want = owed_results.pop_front();
                    if (counted !== want.counted)
                        report_mismatch("counted", counted, want.counted);
                    if (bin_address !== want.bin_address)
                        report_mismatch("bin_address", bin_address, want.bin_address);
                    if (bin_count !== want.bin_count)
                        report_mismatch("bin_count", bin_count, want.bin_count);
                    if (frames_seen !== want.frames_seen)
                        report_mismatch("frames_seen", frames_seen, want.frames_seen);
                end
            end

            // Predict the result of an accepted item
            if (push && !full)
                owed_results.push_back(tally_item(op_t'(op), pos_x, pos_y, pos_z, target_bin));

            owed_now <= owed_results.size();
        end
    end

endmodule

>>> dv/voxel_density_histogram_core_tb.sv
module voxel_density_histogram_core_tb
    import vdh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG = 3'd7;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic [OP_W-1:0]         op = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic [TARGET_W-1:0]     target_bin = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic                    counted;
    logic [ADDR_W-1:0]       bin_address;
    logic [COUNT_W-1:0]      bin_count;
    logic [FRAME_W-1:0]      frames_seen;

    int unsigned mismatch_count;
    int unsigned results_owed;

    // Idle rates in percent and the settings the stimulus aims at
    int send_idle = 29;
    int recv_idle = 65;
    int random_sent = 0;
    int cur_xo = 0;
    int cur_yo = 0;
    int cur_zo = 0;
    int cur_ppn = 10;
    int cur_xb = 40;
    int cur_yb = 40;
    int cur_zb = 40;
    int cycles = 0;

    voxel_density_histogram_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .target_bin  (target_bin),
        .empty       (empty),
        .pop         (pop),
        .counted     (counted),
        .bin_address (bin_address),
        .bin_count   (bin_count),
        .frames_seen (frames_seen)
    );

    voxel_density_histogram_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .target_bin  (target_bin),
        .empty       (empty),
        .pop         (pop),
        .counted     (counted),
        .bin_address (bin_address),
        .bin_count   (bin_count),
        .frames_seen (frames_seen),
        .mismatches  (mismatch_count),
        .pending     (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one item and hold it until it is taken
    task automatic send_item(op_t kind, int px, int py, int pz, int tgt);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        op         <= kind;
        pos_x      <= POS_W'(px);
        pos_y      <= POS_W'(py);
        pos_z      <= POS_W'(pz);
        target_bin <= TARGET_W'(tgt);
        do @(posedge clk); while (full);
    endtask

    // Drop push and wait for every owed result
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // Write every register, and the unused index when asked
    task automatic apply_setting(int xo, int yo, int zo, int dens,
                                 int xb, int yb, int zb, bit spare);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_Z_ORIGIN, zo);
        write_reg(REG_PPN, dens);
        write_reg(REG_X_BINS, xb);
        write_reg(REG_Y_BINS, yb);
        write_reg(REG_Z_BINS, zb);
        if (spare)
            write_reg(SPARE_REG, $urandom);
        cfg_we  <= 1'b0;
        cur_xo  = 32'(signed'(POS_W'(xo)));
        cur_yo  = 32'(signed'(POS_W'(yo)));
        cur_zo  = 32'(signed'(POS_W'(zo)));
        cur_ppn = dens & 8'hFF;
        cur_xb  = xb & 9'h1FF;
        cur_yb  = yb & 9'h1FF;
        cur_zb  = zb & 9'h1FF;
    endtask

    // Pick a coordinate that lands near a random grid point of one axis
    function automatic int aim_axis(int org, int nbins);
        int idx;
        int frac;
        if (cur_ppn == 0 || nbins == 0)
            return org + $urandom_range(8191) - 4096;
        idx  = $urandom_range(nbins - 1);
        frac = $urandom_range(4094) - 2047;
        return org + ((idx * 4096 + frac) / cur_ppn);
    endfunction

    function automatic int rand_pos();
        return 32'(signed'(POS_W'($urandom)));
    endfunction

    // Random items, mostly aimed adds; optionally pause once for a full drain
    task automatic random_items(int count, int hold_at);
        int sel;
        int span_top;
        longint span;
        for (int n = 0; n < count; n++) begin
            if (random_sent < 433) begin
                send_idle = 29;
                recv_idle = 65;
            end
            else if (random_sent < 866) begin
                send_idle = 65;
                recv_idle = 29;
            end
            else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n == hold_at)
                drain();
            span = longint'(cur_xb) * cur_yb * cur_zb;
            if (span < 1)
                span = 1;
            if (span > MAX_BINS)
                span = MAX_BINS;
            span_top = int'(span) - 1;
            sel = $urandom_range(99);
            if (sel < 60)
                send_item(OP_ADD, aim_axis(cur_xo, cur_xb), aim_axis(cur_yo, cur_yb),
                          aim_axis(cur_zo, cur_zb), $urandom);
            else if (sel < 70)
                send_item(OP_ADD, rand_pos(), rand_pos(), rand_pos(), $urandom);
            else if (sel < 80)
                send_item(OP_READ, rand_pos(), rand_pos(), rand_pos(),
                          $urandom_range(span_top));
            else if (sel < 84)
                send_item(OP_READ, rand_pos(), rand_pos(), rand_pos(), $urandom);
            else if (sel < 91)
                send_item(OP_CLEAR, rand_pos(), rand_pos(), rand_pos(),
                          $urandom_range(span_top));
            else if (sel < 94)
                send_item(OP_CLEAR, rand_pos(), rand_pos(), rand_pos(), $urandom);
            else
                send_item(OP_FRAME, rand_pos(), rand_pos(), rand_pos(), $urandom);
            random_sent++;
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: origin bin, rounding near zero, top corner, extremes
        send_item(OP_ADD, 0, 0, 0, 0);
        send_item(OP_ADD, 0, 0, 0, 16'hFFFF);
        send_item(OP_ADD, -204, -204, -204, 0);
        send_item(OP_ADD, -205, 0, 0, 0);
        send_item(OP_ADD, 15974, 15974, 15974, 0);
        send_item(OP_ADD, 0, 16180, 0, 0);
        send_item(OP_ADD, 8388607, 8388607, 8388607, 0);
        send_item(OP_ADD, -8388608, -8388608, -8388608, 0);
        send_item(OP_ADD, 4096, 8192, 2048, 0);
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_READ, -1, -1, -1, 63999);
        send_item(OP_READ, 0, 0, 0, 65535);
        send_item(OP_CLEAR, rand_pos(), rand_pos(), rand_pos(), 0);
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_FRAME, 0, 0, 0, 0);
        send_item(OP_FRAME, 0, 0, 0, 0);
        send_item(OP_ADD, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 65535);
        drain();

        // Small grid at random origins, with one pause for a full drain
        apply_setting(rand_pos(), rand_pos(), rand_pos(), $urandom_range(255, 1), 6, 5, 7, 1'b0);
        random_items(185, 100);

        // Extreme origins, top density, full-size store
        apply_setting(-8388608, 8388607, 0, 255, 256, 256, 1, 1'b0);
        random_items(185, -1);

        // Unit density on a single bin: exact half-way points
        apply_setting(0, 0, 0, 1, 1, 1, 1, 1'b0);
        send_item(OP_ADD, -2047, 0, 0, 0);
        send_item(OP_ADD, -2048, 0, 0, 0);
        send_item(OP_ADD, 2047, 2047, 2047, 0);
        send_item(OP_ADD, 2048, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0);
        random_items(185, -1);

        // Oversized grid: linear addresses past the store
        apply_setting($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                      $urandom_range(8191) - 4096, $urandom_range(255, 1), 511, 300, 257, 1'b0);
        random_items(185, -1);

        // Zero density
        apply_setting(rand_pos(), rand_pos(), rand_pos(), 0, 8, 8, 8, 1'b0);
        random_items(185, -1);

        // Zero bins on one axis
        apply_setting(0, 0, 0, 40, 0, 12, 12, 1'b0);
        random_items(185, -1);

        // Random small grid, with a write to the unused index
        apply_setting(rand_pos(), rand_pos(), rand_pos(), $urandom_range(255, 1),
                      $urandom_range(16, 1), $urandom_range(16, 1), $urandom_range(16, 1), 1'b1);
        random_items(190, -1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
